[design/rklfs_pkg.sv]
package rklfs_pkg;

    // default store dimensions
    localparam int KEY_MAX_DEF  = 32;
    localparam int LOCK_MAX_DEF = 32;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int SIZE_W = 6;
    localparam int OFS_W  = 6;
    localparam int TURN_W = 2;
    localparam int CFG_AW = 1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [SIZE_W-1:0] SIZE_RST = 6'd3;

    localparam logic [CFG_AW-1:0] CFG_KEY_SIZE  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_LOCK_SIZE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_KEY  = 2'd0,
        OP_LOAD_LOCK = 2'd1,
        OP_START     = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT_RD,
        ST_FIT_CMP,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_key;
        logic load_lock;
        logic start;
        logic fit_rd;
        logic fit_step;
        logic rot_rd;
        logic rot_wr;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic row_ok;
        logic last_p;
        logic last_j;
        logic last_i;
        logic last_c;
        logic last_r;
        logic t_last;
        logic out_free;
    } t_stat;

endpackage

[design/rklfs_ctrl.sv]
module rklfs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  rklfs_pkg::t_op     i_op,
    input  rklfs_pkg::t_stat   i_stat,
    output logic               o_s_ready,
    output rklfs_pkg::t_cmd    o_cmd
);

    rklfs_pkg::t_state r_state;
    rklfs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rklfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rklfs_pkg::ST_IDLE: begin
                if (i_s_valid && i_op == rklfs_pkg::OP_START) begin
                    n_state = rklfs_pkg::ST_FIT_RD;
                end
            end
            rklfs_pkg::ST_FIT_RD: begin
                n_state = rklfs_pkg::ST_FIT_CMP;
            end
            rklfs_pkg::ST_FIT_CMP: begin
                if (i_stat.row_ok) begin
                    n_state = i_stat.last_p ? rklfs_pkg::ST_DONE : rklfs_pkg::ST_FIT_RD;
                end else if (i_stat.last_i && i_stat.last_j) begin
                    n_state = i_stat.t_last ? rklfs_pkg::ST_DONE : rklfs_pkg::ST_ROT_RD;
                end else begin
                    n_state = rklfs_pkg::ST_FIT_RD;
                end
            end
            rklfs_pkg::ST_ROT_RD: begin
                if (i_stat.last_c) begin
                    n_state = rklfs_pkg::ST_ROT_WR;
                end
            end
            rklfs_pkg::ST_ROT_WR: begin
                n_state = i_stat.last_r ? rklfs_pkg::ST_FIT_RD : rklfs_pkg::ST_ROT_RD;
            end
            rklfs_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = rklfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rklfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            rklfs_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    case (i_op)
                        rklfs_pkg::OP_LOAD_KEY:  o_cmd.load_key  = 1'b1;
                        rklfs_pkg::OP_LOAD_LOCK: o_cmd.load_lock = 1'b1;
                        rklfs_pkg::OP_START:     o_cmd.start     = 1'b1;
                        default:                 o_cmd           = '0;
                    endcase
                end
            end
            rklfs_pkg::ST_FIT_RD:  o_cmd.fit_rd   = 1'b1;
            rklfs_pkg::ST_FIT_CMP: o_cmd.fit_step = 1'b1;
            rklfs_pkg::ST_ROT_RD:  o_cmd.rot_rd   = 1'b1;
            rklfs_pkg::ST_ROT_WR:  o_cmd.rot_wr   = 1'b1;
            rklfs_pkg::ST_DONE:    o_cmd.out_load = i_stat.out_free;
            default:               o_cmd          = '0;
        endcase
    end

endmodule

[design/rklfs_dpath.sv]
module rklfs_dpath #(
    parameter int KEY_MAX  = rklfs_pkg::KEY_MAX_DEF,
    parameter int LOCK_MAX = rklfs_pkg::LOCK_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rklfs_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [rklfs_pkg::SIZE_W-1:0]  i_cfg_wdata,
    input  logic [rklfs_pkg::ROW_W-1:0]   i_row,
    input  logic [rklfs_pkg::COL_W-1:0]   i_col,
    input  logic                          i_cell_bit,
    input  rklfs_pkg::t_cmd               i_cmd,
    input  logic                          i_m_ready,
    output rklfs_pkg::t_stat              o_stat,
    output logic                          o_m_valid,
    output logic                          o_found,
    output logic [rklfs_pkg::TURN_W-1:0]  o_turns,
    output logic [rklfs_pkg::OFS_W-1:0]   o_row_offset,
    output logic [rklfs_pkg::OFS_W-1:0]   o_col_offset
);

    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LAW = (LOCK_MAX > 1) ? $clog2(LOCK_MAX) : 1;
    localparam int SW  = $clog2(KEY_MAX + 1);
    localparam int NW  = $clog2(LOCK_MAX + 1);
    localparam int OW  = $clog2(KEY_MAX + LOCK_MAX);
    localparam int AW  = OW + 2;
    localparam int EW  = KEY_MAX + LOCK_MAX;
    localparam int RW  = rklfs_pkg::ROW_W;
    localparam int CW  = rklfs_pkg::COL_W;
    localparam int FW  = rklfs_pkg::OFS_W;
    localparam logic [AW-1:0] ONE = 1;
    localparam logic [AW-1:0] TWO = 2;

    // config
    logic [rklfs_pkg::SIZE_W-1:0] r_key_size;
    logic [rklfs_pkg::SIZE_W-1:0] r_lock_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size  <= rklfs_pkg::SIZE_RST;
            r_lock_size <= rklfs_pkg::SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rklfs_pkg::CFG_KEY_SIZE:  r_key_size  <= i_cfg_wdata;
                rklfs_pkg::CFG_LOCK_SIZE: r_lock_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sizes in use: zero reads as one, large values saturate
    logic [6:0]    ks7, ls7, m7, n7;
    logic [SW-1:0] m;
    logic [NW-1:0] n;

    always_comb begin
        ks7 = {1'b0, r_key_size};
        ls7 = {1'b0, r_lock_size};
        if (ks7 == 7'd0)               m7 = 7'd1;
        else if (ks7 > 7'(KEY_MAX))    m7 = 7'(KEY_MAX);
        else                           m7 = ks7;
        if (ls7 == 7'd0)               n7 = 7'd1;
        else if (ls7 > 7'(LOCK_MAX))   n7 = 7'(LOCK_MAX);
        else                           n7 = ls7;
        m = m7[SW-1:0];
        n = n7[NW-1:0];
    end

    // search counters
    logic [1:0]     r_t;
    logic [OW-1:0]  r_i, r_j;
    logic [LAW-1:0] r_p;
    logic [KAW-1:0] r_r, r_c;
    logic           r_hit;
    logic           r_a_in;

    logic [AW-1:0] m_w, n_w, p_w, i_w, j_w, c_w, r_w, lim_w;
    logic [AW-1:0] a_w, s_w, s_mag, rot_a_w;
    logic          s_neg, a_in;
    logic          last_p, last_i, last_j, last_c, last_r;

    always_comb begin
        m_w     = AW'(m);
        n_w     = AW'(n);
        p_w     = AW'(r_p);
        i_w     = AW'(r_i);
        j_w     = AW'(r_j);
        c_w     = AW'(r_c);
        r_w     = AW'(r_r);
        lim_w   = n_w + m_w - TWO;
        last_p  = (p_w == n_w - ONE);
        last_i  = (i_w == lim_w);
        last_j  = (j_w == lim_w);
        last_c  = (c_w == m_w - ONE);
        last_r  = (r_w == m_w - ONE);
        // turned-key row that overlaps lock row p
        a_w     = p_w + m_w - ONE - i_w;
        a_in    = !a_w[AW-1] && (a_w < m_w);
        // horizontal shift of the key row onto the lock
        s_w     = j_w + ONE - m_w;
        s_neg   = s_w[AW-1];
        s_mag   = s_neg ? (~s_w + ONE) : s_w;
        // rotation source row: old[m-1-c]
        rot_a_w = m_w - ONE - c_w;
    end

    // stores
    logic [KEY_MAX-1:0]  r_key_mem  [KEY_MAX];
    logic [KEY_MAX-1:0]  r_tk0_mem  [KEY_MAX];
    logic [KEY_MAX-1:0]  r_tk1_mem  [KEY_MAX];
    logic [LOCK_MAX-1:0] r_lock_mem [LOCK_MAX];
    logic [KEY_MAX-1:0]  r_key_rd, r_tk0_rd, r_tk1_rd;
    logic [LOCK_MAX-1:0] r_lock_rd;

    logic [RW+KAW-1:0] krow_x;
    logic [CW+KAW-1:0] kcol_x;
    logic [RW+LAW-1:0] lrow_x;
    logic [CW+LAW-1:0] lcol_x;
    logic              key_we, lock_we;
    logic [KAW-1:0]    key_raddr;
    logic [KEY_MAX-1:0] src_rd, n_acc, r_acc;
    logic              r_cap_vld;
    logic [KAW-1:0]    r_cap_col;

    always_comb begin
        krow_x    = {{KAW{1'b0}}, i_row};
        kcol_x    = {{KAW{1'b0}}, i_col};
        lrow_x    = {{LAW{1'b0}}, i_row};
        lcol_x    = {{LAW{1'b0}}, i_col};
        key_we    = i_cmd.load_key && ({2'b00, i_row} < 7'(KEY_MAX))
                    && ({2'b00, i_col} < 7'(KEY_MAX));
        lock_we   = i_cmd.load_lock && ({2'b00, i_row} < 7'(LOCK_MAX))
                    && ({2'b00, i_col} < 7'(LOCK_MAX));
        key_raddr = i_cmd.rot_rd ? rot_a_w[KAW-1:0] : a_w[KAW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[krow_x[KAW-1:0]][kcol_x[KAW-1:0]] <= i_cell_bit;
        end
        r_key_rd <= r_key_mem[key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lock_we) begin
            r_lock_mem[lrow_x[LAW-1:0]][lcol_x[LAW-1:0]] <= i_cell_bit;
        end
        r_lock_rd <= r_lock_mem[r_p];
    end

    // turned copies: turns 1 and 3 live in tk0, turn 2 in tk1
    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_wr && !r_t[0]) begin
            r_tk0_mem[r_r] <= n_acc;
        end
        r_tk0_rd <= r_tk0_mem[key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_wr && r_t[0]) begin
            r_tk1_mem[r_r] <= n_acc;
        end
        r_tk1_rd <= r_tk1_mem[key_raddr];
    end

    always_comb begin
        case (r_t)
            2'd0:    src_rd = r_key_rd;
            2'd2:    src_rd = r_tk1_rd;
            default: src_rd = r_tk0_rd;
        endcase
    end

    // rotation: new[r][c] = old[m-1-c][r], one source row per cycle
    always_comb begin
        n_acc = r_acc;
        if (r_cap_vld) begin
            n_acc[r_cap_col] = src_rd[r_r];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_cap_col <= r_c;
    end

    // fit check of one lock row
    logic [KEY_MAX-1:0]  mask_m, trow;
    logic [LOCK_MAX-1:0] full, lk, kb;
    logic [EW-1:0]       ext, sh;
    logic                row_ok;

    always_comb begin
        for (int b = 0; b < KEY_MAX; b++) begin
            mask_m[b] = (AW'(b) < m_w);
        end
        for (int b = 0; b < LOCK_MAX; b++) begin
            full[b] = (AW'(b) < n_w);
        end
        trow   = src_rd & mask_m;
        ext    = {{LOCK_MAX{1'b0}}, trow};
        sh     = s_neg ? (ext >> s_mag) : (ext << s_mag);
        kb     = r_a_in ? (sh[LOCK_MAX-1:0] & full) : '0;
        lk     = r_lock_rd & full;
        row_ok = ((lk & kb) == '0) && ((lk | kb) == full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_p       <= '0;
            r_r       <= '0;
            r_c       <= '0;
            r_hit     <= 1'b0;
            r_a_in    <= 1'b0;
            r_cap_vld <= 1'b0;
        end else begin
            r_cap_vld <= i_cmd.rot_rd;
            if (i_cmd.fit_rd) begin
                r_a_in <= a_in;
            end
            if (i_cmd.start) begin
                r_t   <= '0;
                r_i   <= '0;
                r_j   <= '0;
                r_p   <= '0;
                r_r   <= '0;
                r_c   <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.fit_step) begin
                if (row_ok && last_p) begin
                    r_hit <= 1'b1;
                end else if (row_ok) begin
                    r_p <= r_p + 1'b1;
                end else begin
                    r_p <= '0;
                    if (!last_j) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_j <= '0;
                        r_i <= last_i ? '0 : r_i + 1'b1;
                    end
                end
            end else if (i_cmd.rot_rd) begin
                if (!last_c) begin
                    r_c <= r_c + 1'b1;
                end
            end else if (i_cmd.rot_wr) begin
                r_c <= '0;
                if (last_r) begin
                    r_r <= '0;
                    r_t <= r_t + 1'b1;
                end else begin
                    r_r <= r_r + 1'b1;
                end
            end
        end
    end

    // result word register
    logic [OW+FW-1:0] i_x, j_x;
    logic             r_m_valid;

    assign i_x = {{FW{1'b0}}, r_i};
    assign j_x = {{FW{1'b0}}, r_j};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_found      <= r_hit;
            o_turns      <= r_hit ? r_t : '0;
            o_row_offset <= r_hit ? i_x[FW-1:0] : '0;
            o_col_offset <= r_hit ? j_x[FW-1:0] : '0;
        end
    end

    assign o_m_valid = r_m_valid;

    always_comb begin
        o_stat.row_ok   = row_ok;
        o_stat.last_p   = last_p;
        o_stat.last_j   = last_j;
        o_stat.last_i   = last_i;
        o_stat.last_c   = last_c;
        o_stat.last_r   = last_r;
        o_stat.t_last   = (r_t == 2'd3);
        o_stat.out_free = !r_m_valid || i_m_ready;
    end

endmodule

[design/rotated_key_lock_fit_search.sv]
// Load words (key or lock cell) are accepted while idle; ready stays high in idle.
// A start word holds ready low for the search: for each of the (n+m-1)^2 offsets
// of each of up to 4 turns, each lock row checked is read, then compared; each of
// up to 3 quarter turns reads the key rows (one key row read per cycle) and writes
// each new row; last the result register is loaded (later while an older result is still stalled).
// Synchronous active-low reset clears control and sets both sizes to 3; stores stay undefined.
module rotated_key_lock_fit_search #(
    parameter int KEY_MAX  = rklfs_pkg::KEY_MAX_DEF,
    parameter int LOCK_MAX = rklfs_pkg::LOCK_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [rklfs_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [rklfs_pkg::SIZE_W-1:0]      i_cfg_wdata,
    // input words
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [rklfs_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // row, col, cell_bit
    input  logic [rklfs_pkg::OP_W-1:0]        i_s_axis_tuser,  // op
    // result words
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [rklfs_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,  // turns, row_ofs, col_ofs
    output logic [0:0]                        o_m_axis_tuser   // found
);

    rklfs_pkg::t_cmd  cmd;
    rklfs_pkg::t_stat stat;

    logic                          found;
    logic [rklfs_pkg::TURN_W-1:0]  turns;
    logic [rklfs_pkg::OFS_W-1:0]   row_offset;
    logic [rklfs_pkg::OFS_W-1:0]   col_offset;

    // sequencer: idle/load, fit read/compare, quarter turn, result
    rklfs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_op      (rklfs_pkg::t_op'(i_s_axis_tuser)),
        .i_stat    (stat),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (cmd)
    );

    // stores, counters, row compare and result register
    rklfs_dpath #(
        .KEY_MAX  (KEY_MAX),
        .LOCK_MAX (LOCK_MAX)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_row        (i_s_axis_tdata[4:0]),
        .i_col        (i_s_axis_tdata[9:5]),
        .i_cell_bit   (i_s_axis_tdata[10]),
        .i_cmd        (cmd),
        .i_m_ready    (i_m_axis_tready),
        .o_stat       (stat),
        .o_m_valid    (o_m_axis_tvalid),
        .o_found      (found),
        .o_turns      (turns),
        .o_row_offset (row_offset),
        .o_col_offset (col_offset)
    );

    // tdata: turns [1:0], row_offset [7:2], col_offset [13:8], zero pad above
    assign o_m_axis_tdata = {2'b00, col_offset, row_offset, turns};
    assign o_m_axis_tuser = found;

endmodule

[design/rklfs_checker.sv]
module rklfs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [rklfs_pkg::OP_W-1:0]        i_s_axis_tuser,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [rklfs_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [0:0]                        o_m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // a start word puts the block into search
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == rklfs_pkg::OP_START
            |=> !o_s_axis_tready)
        else $error("ready still high after start");

    // no fit means zero turn and offsets
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("miss with nonzero placement");

    // a result only comes out of a search
    a_out_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result word without search");

endmodule

bind rotated_key_lock_fit_search rklfs_checker u_chk (.*);

[sim/fit_checker.sv]
`timescale 1ns / 100ps

// Watches the config port and both streams, keeps its own copy of the key,
// the lock and the sizes, and predicts the search result of each start word.
module fit_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rklfs_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [rklfs_pkg::SIZE_W-1:0]      i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [rklfs_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // row, col, cell_bit
    input  logic [rklfs_pkg::OP_W-1:0]        i_s_axis_tuser,  // op
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [rklfs_pkg::M_TDATA_W-1:0]   i_m_axis_tdata,  // turns, row_ofs, col_ofs
    input  logic [0:0]                        i_m_axis_tuser,  // found
    output int                                o_mismatches,
    output int                                o_outstanding
);
    import rklfs_pkg::*;

    localparam int SIDE = 32;

    typedef struct packed {
        logic              found;
        logic [TURN_W-1:0] turns;
        logic [OFS_W-1:0]  row_ofs;
        logic [OFS_W-1:0]  col_ofs;
    } t_fit;

    logic [SIDE-1:0]   key_rows  [SIDE];
    logic [SIDE-1:0]   lock_rows [SIDE];
    logic [SIDE-1:0]   spun_key  [SIDE];
    logic [SIZE_W-1:0] key_size_reg;
    logic [SIZE_W-1:0] lock_size_reg;
    t_fit              fit_queue [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // 0 counts as 1, anything past the store saturates
    function automatic int used_side(logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > SIDE) return SIDE;
        return int'(v);
    endfunction

    function automatic logic [63:0] low_ones(int w);
        return (64'd1 << w) - 64'd1;
    endfunction

    // every lock cell plus the overlapping key bit must be exactly 1
    function automatic bit placement_fits(int m, int n, int i, int j);
        logic [63:0] full;
        logic [63:0] lk;
        logic [63:0] kb;
        int a;
        int s;
        full = low_ones(n);
        for (int p = 0; p < n; p++) begin
            lk = {32'd0, lock_rows[p]} & full;
            kb = '0;
            a  = p + m - 1 - i;
            if (a >= 0 && a < m) begin
                s  = j - (m - 1);
                kb = {32'd0, spun_key[a]} & low_ones(m);
                kb = (s >= 0) ? (kb << s) : (kb >> -s);
                kb = kb & full;
            end
            if ((lk & kb) != 0 || (lk | kb) != full) return 1'b0;
        end
        return 1'b1;
    endfunction

    // clockwise quarter turn of the working copy
    function automatic void spin_key(int m);
        logic [SIDE-1:0] nxt [SIDE];
        for (int r = 0; r < SIDE; r++) nxt[r] = '0;
        for (int r = 0; r < m; r++)
            for (int c = 0; c < m; c++)
                nxt[r][c] = spun_key[m - 1 - c][r];
        for (int r = 0; r < SIDE; r++) spun_key[r] = nxt[r];
    endfunction

    // turns, then rows, then columns; first fit wins, all zero on a miss
    function automatic t_fit predict_fit();
        t_fit res;
        int   m;
        int   n;
        m   = used_side(key_size_reg);
        n   = used_side(lock_size_reg);
        res = '0;
        for (int r = 0; r < SIDE; r++) spun_key[r] = key_rows[r];
        for (int t = 0; t < 4; t++) begin
            for (int i = 0; i < n + m - 1; i++)
                for (int j = 0; j < n + m - 1; j++)
                    if (placement_fits(m, n, i, j)) begin
                        res.found   = 1'b1;
                        res.turns   = t[TURN_W-1:0];
                        res.row_ofs = i[OFS_W-1:0];
                        res.col_ofs = j[OFS_W-1:0];
                        return res;
                    end
            spin_key(m);
        end
        return res;
    endfunction

    task automatic flag_word(string why, t_fit want, t_fit got);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("fit_checker: %s: exp found=%0d turns=%0d row=%0d col=%0d, %s",
                     why, want.found, want.turns, want.row_ofs, want.col_ofs,
                     $sformatf("got found=%0d turns=%0d row=%0d col=%0d",
                               got.found, got.turns, got.row_ofs, got.col_ofs));
    endtask

    always @(posedge i_clk) begin : watch
        t_fit got;
        t_fit want;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        if (!i_rst_n) begin
            key_size_reg  = SIZE_RST;
            lock_size_reg = SIZE_RST;
            fit_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_KEY_SIZE:  key_size_reg  = i_cfg_wdata;
                    CFG_LOCK_SIZE: lock_size_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            // result side first: a word leaving now belongs to an older start
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.found   = i_m_axis_tuser[0];
                got.turns   = i_m_axis_tdata[TURN_W-1:0];
                got.row_ofs = i_m_axis_tdata[TURN_W +: OFS_W];
                got.col_ofs = i_m_axis_tdata[TURN_W + OFS_W +: OFS_W];
                if (fit_queue.size() == 0) begin
                    flag_word("result with no search pending", '0, got);
                end else begin
                    want = fit_queue.pop_front();
                    if (got.found != want.found || got.turns != want.turns ||
                        got.row_ofs != want.row_ofs || got.col_ofs != want.col_ofs)
                        flag_word("wrong result", want, got);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                row = i_s_axis_tdata[ROW_W-1:0];
                col = i_s_axis_tdata[ROW_W +: COL_W];
                case (t_op'(i_s_axis_tuser))
                    OP_LOAD_KEY:  key_rows[row][col]  = i_s_axis_tdata[ROW_W + COL_W];
                    OP_LOAD_LOCK: lock_rows[row][col] = i_s_axis_tdata[ROW_W + COL_W];
                    OP_START:     fit_queue.push_back(predict_fit());
                    default: ;
                endcase
            end
        end
        o_outstanding = fit_queue.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the key/lock fit search. Checking lives in
// fit_checker, which sits on the same wires as the block.
module tb_top;
    import rklfs_pkg::*;

    // op 3 is not decoded by the block; it must be dropped without a result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Worst correct search, 12x12 key over a 10x10 lock with no fit:
    // 4 turns of 21*21 offsets, 10 lock rows checked at each, plus 3 quarter
    // turns of the key, with no word moving. Allow about five times that.
    localparam int STALL_LIMIT = 200_000;

    localparam int RANDOM_WORDS = 760;

    // 3x3 demo: key cells (1,0) (2,1) (2,2) set; lock is full except
    // (1,2) and (2,1). Bit index is row*3 + col.
    localparam logic [8:0] DEMO_KEY  = 9'h188;
    localparam logic [8:0] DEMO_LOCK = 9'h15F;

    logic                   i_clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_AW-1:0]      cfg_addr  = '0;
    logic [SIZE_W-1:0]      cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [S_TDATA_W-1:0]   s_data    = '0;   // row, col, cell_bit
    logic [OP_W-1:0]        s_user    = '0;   // op
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [M_TDATA_W-1:0]   m_data;          // turns, row_ofs, col_ofs
    logic [0:0]             m_user;          // found

    int mismatches;
    int outstanding;

    // cells written so far; a search must never read a cell that is not
    logic [31:0] key_loaded  [32];
    logic [31:0] lock_loaded [32];
    int key_side;
    int lock_side;
    int words_sent    = 0;
    int word_calm     = 0;   // words left in the current no-gap run
    int idle_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    rotated_key_lock_fit_search u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    fit_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // Watchdog: any word moving on either stream restarts the count.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Result side: a random stall before each word, with occasional runs
    // of back-to-back acceptance. Ready also drops while nothing is offered,
    // so stalls land on every phase of the search.
    initial begin : result_side
        int stall;
        int calm;
        calm = 0;
        forever begin
            if (calm > 0) begin
                stall = 0;
                calm--;
            end else begin
                stall = $urandom_range(0, 19);
                if ($urandom_range(0, 9) == 0) calm = $urandom_range(5, 30);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    function automatic int side_of(int v);
        if (v == 0) return 1;
        if (v > 32) return 32;
        return v;
    endfunction

    // Send one word after a random gap. Valid stays up when the next word
    // follows without a gap, so it is never dropped and raised in one step.
    task automatic put_word(logic [OP_W-1:0] op, int row, int col, logic b);
        int gap;
        if (word_calm > 0) begin
            gap = 0;
            word_calm--;
        end else begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0) word_calm = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= S_TDATA_W'({b, col[COL_W-1:0], row[ROW_W-1:0]});
        do @(posedge i_clk); while (!s_ready);
        if (op == OP_LOAD_KEY)  key_loaded[row][col]  = 1'b1;
        if (op == OP_LOAD_LOCK) lock_loaded[row][col] = 1'b1;
        if (op != OP_UNUSED)    words_sent++;
    endtask

    task automatic kick_search();
        put_word(OP_START, $urandom_range(0, 31), $urandom_range(0, 31),
                 1'($urandom_range(0, 1)));
    endtask

    // Loads anywhere in the 32x32 stores plus dropped op-3 words.
    task automatic scatter(int count);
        logic [OP_W-1:0] op;
        repeat (count) begin
            case ($urandom_range(0, 2))
                0:       op = OP_LOAD_KEY;
                1:       op = OP_LOAD_LOCK;
                default: op = OP_UNUSED;
            endcase
            put_word(op, $urandom_range(0, 31), $urandom_range(0, 31),
                     1'($urandom_range(0, 1)));
        end
    endtask

    // Write any never-loaded cell inside the sizes in use.
    task automatic fill_gaps();
        for (int r = 0; r < key_side; r++)
            for (int c = 0; c < key_side; c++)
                if (!key_loaded[r][c])
                    put_word(OP_LOAD_KEY, r, c, 1'($urandom_range(0, 1)));
        for (int r = 0; r < lock_side; r++)
            for (int c = 0; c < lock_side; c++)
                if (!lock_loaded[r][c])
                    put_word(OP_LOAD_LOCK, r, c, 1'($urandom_range(0, 1)));
    endtask

    // Build a key/lock pair that fits at a chosen turn and offset, load it
    // whole and start a search. With spoil set, one lock cell is then
    // rewritten at random, which usually breaks that fit.
    task automatic plant_fit(bit spoil);
        logic [31:0] shape [32];   // key as it looks after the chosen turn
        int m;
        int n;
        int quarter;
        int ofs_r;
        int ofs_c;
        int kr;
        int kc;
        int a;
        int b;
        logic v;
        m       = key_side;
        n       = lock_side;
        quarter = $urandom_range(0, 3);
        ofs_r   = $urandom_range(0, n + m - 2);
        ofs_c   = $urandom_range(0, n + m - 2);
        for (int r = 0; r < 32; r++) shape[r] = $urandom;
        // stored cell (r,c) lands on (c, m-1-r) after each clockwise turn
        for (int r = 0; r < m; r++)
            for (int c = 0; c < m; c++) begin
                kr = r;
                kc = c;
                repeat (quarter) begin
                    b  = kr;
                    kr = kc;
                    kc = m - 1 - b;
                end
                put_word(OP_LOAD_KEY, r, c, shape[kr][kc]);
            end
        // lock cell is the complement of whatever key bit lands on it
        for (int p = 0; p < n; p++)
            for (int q = 0; q < n; q++) begin
                a = p + m - 1 - ofs_r;
                b = q + m - 1 - ofs_c;
                v = (a >= 0 && a < m && b >= 0 && b < m) ? shape[a][b] : 1'b0;
                put_word(OP_LOAD_LOCK, p, q, !v);
            end
        if (spoil)
            put_word(OP_LOAD_LOCK, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     1'($urandom_range(0, 1)));
        kick_search();
    endtask

    // Size writes go out back to back; both registers every time.
    task automatic set_sizes(int key_val, int lock_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_KEY_SIZE;
        cfg_wdata <= SIZE_W'(key_val);
        @(posedge i_clk);
        cfg_addr  <= CFG_LOCK_SIZE;
        cfg_wdata <= SIZE_W'(lock_val);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        key_side  = side_of(key_val);
        lock_side = side_of(lock_val);
    endtask

    // Wait for every predicted result, then keep idle so a trailing load
    // has landed in the block before the sizes change.
    // The count is read on the falling edge, clear of the checker's update.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly 1..5 so searches stay short; now and then 0 (taken as 1) or 6.
    function automatic int rand_side();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 6;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    initial begin : stimulus
        int goal;
        for (int r = 0; r < 32; r++) begin
            key_loaded[r]  = '0;
            lock_loaded[r] = '0;
        end
        key_side  = 3;
        lock_side = 3;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset sizes (3x3), known fitting pair, unused op,
        // corner loads outside the sizes in use, then a repeat search.
        for (int k = 0; k < 9; k++) put_word(OP_LOAD_KEY, k / 3, k % 3, DEMO_KEY[k]);
        for (int k = 0; k < 9; k++) put_word(OP_LOAD_LOCK, k / 3, k % 3, DEMO_LOCK[k]);
        kick_search();
        put_word(OP_UNUSED, 31, 31, 1'b1);
        put_word(OP_LOAD_KEY, 31, 31, 1'b1);
        put_word(OP_LOAD_LOCK, 31, 31, 1'b0);
        put_word(OP_LOAD_LOCK, 0, 31, 1'b1);
        kick_search();
        drain();

        // both sizes written as zero: the block works with 1x1
        set_sizes(0, 0);
        plant_fit(1'b0);
        scatter(3);
        fill_gaps();
        kick_search();
        drain();

        // Random phases at small sizes. Most sequences plant a real fit so
        // the scan runs deep; the rest are spoiled fits, stray loads with
        // dropped words, and plain re-searches of what is stored.
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            set_sizes(rand_side(), rand_side());
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: plant_fit(1'b0);
                    6:                plant_fit(1'b1);
                    7, 8: begin
                        scatter($urandom_range(1, 8));
                        fill_gaps();
                        kick_search();
                    end
                    default: begin
                        fill_gaps();
                        kick_search();
                    end
                endcase
            end
            drain();
        end

        // Larger key and lock. A planted fit keeps the first search short,
        // the spoiled one may scan much further.
        set_sizes(12, 10);
        plant_fit(1'b0);
        put_word(OP_LOAD_LOCK, $urandom_range(0, 9), $urandom_range(0, 9),
                 1'($urandom_range(0, 1)));
        kick_search();
        drain();

        // largest key in use over a 1x1 lock
        set_sizes(12, 1);
        scatter(6);
        fill_gaps();
        kick_search();
        drain();

        // 1x1 key over a 12x12 lock
        set_sizes(1, 12);
        scatter(6);
        fill_gaps();
        kick_search();
        drain();

        // let any stray result show up before the verdict
        repeat (64) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
